@@ src/i2cms_pkg.sv @@
// Shared types, sizes and codes of the I2C master transfer sequencer.
package i2cms_pkg;

    // Sizes (STORE_BYTES must be a power of two)
    localparam int MAX_MSGS    = 8;
    localparam int STORE_BYTES = 256;
    localparam int MSG_W       = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int TOT_W       = MSG_W + 1;
    localparam int STORE_AW    = $clog2(STORE_BYTES);

    // Request modes
    localparam logic [1:0] MODE_DESC  = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_IRQ   = 2'd3;

    // Controller resume actions
    localparam logic [1:0] CON_NONE = 2'd0;
    localparam logic [1:0] CON_ACK  = 2'd1;
    localparam logic [1:0] CON_NACK = 2'd2;

    // Controller status words
    localparam logic [7:0] STAT_START_RD = 8'hB0;
    localparam logic [7:0] STAT_START_WR = 8'hF0;
    localparam logic [7:0] STAT_STOP_RD  = 8'h90;
    localparam logic [7:0] STAT_STOP_WR  = 8'hD0;

    // Sequencer phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_START = 5'b00010,
        PH_READ  = 5'b00100,
        PH_WRITE = 5'b01000,
        PH_STOP  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] msg_index;
        logic [6:0] slave_addr;
        logic       read_flag;
        logic [8:0] msg_length;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
        logic [3:0] msg_count;
        logic       no_ack;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       ds_write;
        logic [7:0] ds_value;
        logic [7:0] stat_value;
        logic [1:0] con_action;
        logic       irq_clear;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic       done_res;
        logic       status;
    } t_out;

    // Result of one request plus a flag: data byte comes from the store read
    typedef struct packed {
        logic ds_mem;
        t_out out;
    } t_res;

    typedef struct packed {
        logic [6:0] addr;
        logic       rd;
        logic [8:0] len;
    } t_desc;

    typedef struct packed {
        logic load_first;
        logic load_next;
    } t_desc_ctl;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [STORE_AW-1:0] raddr;
    } t_store_req;

endpackage

@@ src/i2cms_in_stage.sv @@
// Input request register with stall generation.
module i2cms_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  i2cms_pkg::t_in   i_in_data,
    input  logic             i_free,
    output logic             o_in_stall,
    output logic             o_fire,
    output i2cms_pkg::t_in   o_item
);
    import i2cms_pkg::*;

    logic r_valid;
    t_in  r_item;
    logic w_accept;

    // Process the held request whenever the result register can take it
    assign o_fire     = r_valid & i_free;
    assign o_in_stall = r_valid & ~o_fire;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_item     = r_item;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

endmodule

@@ src/i2cms_desc.sv @@
// Message descriptor slots and the copy of the current message descriptor.
module i2cms_desc (
    input  logic                        i_clk,
    input  logic                        i_fire,
    input  i2cms_pkg::t_in              i_item,
    input  i2cms_pkg::t_desc_ctl        i_ctl,
    input  logic [i2cms_pkg::MSG_W-1:0] i_cur_slot,
    output i2cms_pkg::t_desc            o_cur,
    output i2cms_pkg::t_desc            o_first,
    output i2cms_pkg::t_desc            o_next
);
    import i2cms_pkg::*;

    t_desc             r_desc [MAX_MSGS];
    t_desc             r_cur;
    t_desc             w_wdesc;
    logic              w_we;
    logic [MSG_W-1:0]  w_wslot;
    logic [MSG_W-1:0]  w_nxt;

    // Decode descriptor load
    assign w_we    = i_fire && (i_item.mode == MODE_DESC) &&
                     (32'(i_item.msg_index) < MAX_MSGS);
    assign w_wslot = MSG_W'(i_item.msg_index);
    assign w_wdesc = '{addr: i_item.slave_addr, rd: i_item.read_flag,
                       len: i_item.msg_length};

    // Slot after the current one, wrapping
    assign w_nxt = (i_cur_slot == MSG_W'(MAX_MSGS - 1)) ? '0 : i_cur_slot + MSG_W'(1);

    assign o_cur   = r_cur;
    assign o_first = r_desc[0];
    assign o_next  = r_desc[w_nxt];

    // Write slots
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_desc[w_wslot] <= w_wdesc;
        end
    end

    // Keep the current copy in step with slot loads and message changes
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_first) begin
            r_cur <= r_desc[0];
        end else if (i_ctl.load_next) begin
            r_cur <= r_desc[w_nxt];
        end else if (w_we && (w_wslot == i_cur_slot)) begin
            r_cur <= w_wdesc;
        end
    end

endmodule

@@ src/i2cms_store.sv @@
// Byte store memory: one write port, one registered read port.
module i2cms_store (
    input  logic                   i_clk,
    input  i2cms_pkg::t_store_req  i_req,
    input  logic                   i_rd_en,
    output logic [7:0]             o_rdata
);
    import i2cms_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    assign o_rdata = r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, held while the result waits
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

@@ src/i2cms_seq.sv @@
// Transfer phase machine, message and byte pointers, and result decode.
module i2cms_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  i2cms_pkg::t_in              i_item,
    input  i2cms_pkg::t_desc            i_cur,
    input  i2cms_pkg::t_desc            i_first,
    input  i2cms_pkg::t_desc            i_next,
    output i2cms_pkg::t_res             o_res,
    output i2cms_pkg::t_store_req       o_store,
    output i2cms_pkg::t_desc_ctl        o_dctl,
    output logic [i2cms_pkg::MSG_W-1:0] o_cur_slot
);
    import i2cms_pkg::*;

    t_phase               r_phase, n_phase;
    logic [MSG_W-1:0]     r_cur_msg, n_cur_msg;
    logic [8:0]           r_ptr, n_ptr;
    logic [STORE_AW-1:0]  r_base, n_base;
    logic [TOT_W-1:0]     r_total, n_total;

    logic [STORE_AW-1:0]  w_pos;
    logic [8:0]           w_ptr1;
    logic [8:0]           w_tail_ptr;
    logic                 w_last;
    logic                 w_ptr_lt;
    logic                 w_do_first, w_do_next, w_do_stop, w_stop_err;
    logic                 w_do_tail, w_do_wr;
    t_desc                w_sd;

    assign w_pos      = r_base + STORE_AW'(r_ptr);
    assign w_ptr1     = r_ptr + 9'd1;
    assign w_last     = (TOT_W'(r_cur_msg) + TOT_W'(1)) == r_total;
    assign w_ptr_lt   = r_ptr < i_cur.len;
    assign o_cur_slot = r_cur_msg;

    always_comb begin
        o_res      = '0;
        o_store    = '0;
        o_dctl     = '0;
        n_phase    = r_phase;
        n_cur_msg  = r_cur_msg;
        n_ptr      = r_ptr;
        n_base     = r_base;
        n_total    = r_total;
        w_do_first = 1'b0;
        w_do_next  = 1'b0;
        w_do_stop  = 1'b0;
        w_stop_err = 1'b0;
        w_do_tail  = 1'b0;
        w_do_wr    = 1'b0;
        w_tail_ptr = r_ptr;
        w_sd       = i_first;
        o_res.out.con_action = CON_NONE;

        // Decode the request
        case (i_item.mode)
            MODE_DESC: begin
                // slot write lives in the descriptor block
            end
            MODE_DATA: begin
                if (32'(i_item.byte_index) < STORE_BYTES) begin
                    o_store.we    = 1'b1;
                    o_store.waddr = STORE_AW'(i_item.byte_index);
                    o_store.wdata = i_item.data_byte;
                end
            end
            MODE_START: begin
                if (!(r_phase inside {PH_START, PH_READ, PH_WRITE})) begin
                    if (i_item.msg_count == 4'd0) begin
                        n_total = TOT_W'(1);
                    end else if (32'(i_item.msg_count) > MAX_MSGS) begin
                        n_total = TOT_W'(MAX_MSGS);
                    end else begin
                        n_total = TOT_W'(i_item.msg_count);
                    end
                    w_do_first = 1'b1;
                end
            end
            MODE_IRQ: begin
                o_res.out.irq_clear = 1'b1;
                case (r_phase)
                    PH_START: begin
                        if (i_item.no_ack) begin
                            w_do_stop  = 1'b1;
                            w_stop_err = 1'b1;
                        end else if (w_last && !w_ptr_lt) begin
                            w_do_stop = 1'b1;
                        end else if (i_cur.rd) begin
                            n_phase   = PH_READ;
                            w_do_tail = 1'b1;
                        end else begin
                            n_phase = PH_WRITE;
                            w_do_wr = 1'b1;
                        end
                    end
                    PH_WRITE: begin
                        if (i_item.no_ack) begin
                            w_do_stop  = 1'b1;
                            w_stop_err = 1'b1;
                        end else begin
                            w_do_wr = 1'b1;
                        end
                    end
                    PH_READ: begin
                        o_store.we         = 1'b1;
                        o_store.waddr      = w_pos;
                        o_store.wdata      = i_item.rx_byte;
                        o_res.out.rx_valid = 1'b1;
                        o_res.out.rx_index = 8'(w_pos);
                        o_res.out.rx_data  = i_item.rx_byte;
                        n_ptr              = w_ptr1;
                        w_tail_ptr         = w_ptr1;
                        w_do_tail          = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        // Send the next write byte or move on
        if (w_do_wr) begin
            if (w_ptr_lt) begin
                o_res.out.ds_write   = 1'b1;
                o_res.ds_mem         = 1'b1;
                o_res.out.con_action = CON_ACK;
                n_ptr                = w_ptr1;
            end else if (!w_last) begin
                w_do_next = 1'b1;
            end else begin
                w_do_stop = 1'b1;
            end
        end

        // Resume reception, NACK on the last byte, or move on
        if (w_do_tail) begin
            if (w_tail_ptr < i_cur.len) begin
                o_res.out.con_action = ((w_tail_ptr + 9'd1) == i_cur.len) ? CON_NACK
                                                                             : CON_ACK;
            end else if (!w_last) begin
                w_do_next = 1'b1;
            end else begin
                w_do_stop = 1'b1;
            end
        end

        // Issue stop
        if (w_do_stop) begin
            n_phase               = PH_STOP;
            o_res.out.stat_value  = i_cur.rd ? STAT_STOP_RD : STAT_STOP_WR;
            o_res.out.con_action  = CON_ACK;
            o_res.out.done_res    = 1'b1;
            o_res.out.status      = w_stop_err;
        end

        // Issue (repeated) start on the first or next message
        if (w_do_first || w_do_next) begin
            w_sd                 = w_do_next ? i_next : i_first;
            n_phase              = PH_START;
            o_res.out.ds_write   = 1'b1;
            o_res.out.ds_value   = {w_sd.addr, w_sd.rd};
            o_res.out.stat_value = w_sd.rd ? STAT_START_RD : STAT_START_WR;
        end
        if (w_do_first) begin
            n_cur_msg         = '0;
            n_ptr             = '0;
            n_base            = '0;
            o_dctl.load_first = i_fire;
        end
        if (w_do_next) begin
            n_base           = r_base + STORE_AW'(i_cur.len);
            n_cur_msg        = r_cur_msg + MSG_W'(1);
            n_ptr            = '0;
            o_dctl.load_next = i_fire;
        end

        // Gate memory write, point read at the current byte
        o_store.we    = o_store.we & i_fire;
        o_store.raddr = w_pos;
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cur_msg <= '0;
            r_ptr     <= '0;
            r_base    <= '0;
            r_total   <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_cur_msg <= n_cur_msg;
            r_ptr     <= n_ptr;
            r_base    <= n_base;
            r_total   <= n_total;
        end
    end

endmodule

@@ src/i2c_master_transfer_sequencer_top.sv @@
// Top level of the I2C master transfer sequencer with the result register.
//
//  Channel  Signals                          Direction  Moves
//  in       i_in_valid/o_in_stall/i_in_data  to block   one request (load, start or irq)
//  out      o_out_valid/i_out_stall/o_out_data  from block  one controller step per request
//
// A request accepted into the input register is decoded while the result register is
// free, and its result enters the output register at the edge that ends the decode.
// Without output stalls the single decode stage sets the rate: one request per cycle.
// Reset is synchronous, active low, and leaves the sequencer idle; it does not
// clear descriptors or the byte store. A stalled output holds its result and
// the input register keeps one more request before o_in_stall rises.
module i2c_master_transfer_sequencer_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  i2cms_pkg::t_in   i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output i2cms_pkg::t_out  o_out_data
);
    import i2cms_pkg::*;

    logic              w_free;
    logic              w_fire;
    t_in               w_item;
    t_desc             w_cur, w_first, w_next;
    t_desc_ctl         w_dctl;
    logic [MSG_W-1:0]  w_cur_slot;
    t_res              w_res;
    t_store_req        w_store;
    logic [7:0]        w_rdata;

    logic              r_out_valid;
    t_res              r_res;

    // Result register is free when empty or being taken
    assign w_free = ~r_out_valid | ~i_out_stall;

    i2cms_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_free     (w_free),
        .o_in_stall (o_in_stall),
        .o_fire     (w_fire),
        .o_item     (w_item)
    );

    i2cms_desc u_desc (
        .i_clk      (i_clk),
        .i_fire     (w_fire),
        .i_item     (w_item),
        .i_ctl      (w_dctl),
        .i_cur_slot (w_cur_slot),
        .o_cur      (w_cur),
        .o_first    (w_first),
        .o_next     (w_next)
    );

    i2cms_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (w_item),
        .i_cur      (w_cur),
        .i_first    (w_first),
        .i_next     (w_next),
        .o_res      (w_res),
        .o_store    (w_store),
        .o_dctl     (w_dctl),
        .o_cur_slot (w_cur_slot)
    );

    i2cms_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_store),
        .i_rd_en (w_fire),
        .o_rdata (w_rdata)
    );

    // Hold result valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    // Merge the data byte read from the store
    always_comb begin
        o_out_data = r_res.out;
        if (r_res.ds_mem) begin
            o_out_data.ds_value = w_rdata;
        end
    end

    assign o_out_valid = r_out_valid;

    // An open output side never stalls the input
    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output side is free");

    // A processed request always shows up as a result
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed request produced no result");

    // A finished transfer carries a stop status word
    a_done_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.done_res) |->
        (o_out_data.stat_value == STAT_STOP_RD || o_out_data.stat_value == STAT_STOP_WR))
        else $error("transfer end without stop word");

    // Error status only at the end of a transfer
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |-> o_out_data.done_res)
        else $error("no-ack status outside transfer end");

endmodule

@@ tb/i2c_master_transfer_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the I2C master transfer sequencer top level.
module i2c_master_transfer_sequencer_top_tb;
    import i2cms_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PRINT_LIMIT  = 40;

    logic clk      = 1'b0;
    logic rst_n    = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data  = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // Shared run control
    int sent_count  = 0;
    int error_count = 0;
    int idle_pct    = 20;
    int hold_cycles = 0;

    // Controller steps still owed by the block, oldest first
    t_out step_results_q[$];

    // Sequencer state as predicted from the accepted requests
    t_phase           seq_phase = PH_IDLE;
    logic [6:0]       slot_addr [MAX_MSGS];
    logic             slot_rd   [MAX_MSGS];
    logic [8:0]       slot_len  [MAX_MSGS];
    logic [7:0]       byte_mem  [STORE_BYTES];
    logic [TOT_W-1:0] msg_cur   = '0;
    logic [TOT_W-1:0] msg_total = '0;
    logic [8:0]       byte_ptr  = '0;
    logic [7:0]       base_pos  = '0;
    logic             xfer_err  = 1'b0;

    i2c_master_transfer_sequencer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------

    function automatic logic transfer_busy();
        return seq_phase == PH_START || seq_phase == PH_READ || seq_phase == PH_WRITE;
    endfunction

    function automatic logic on_last_msg();
        return (msg_cur + 1) == msg_total;
    endfunction

    // Send the address byte with a (repeated) start
    task automatic open_message(inout t_out res);
        logic [MSG_W-1:0] s;
        s              = msg_cur[MSG_W-1:0];
        seq_phase      = PH_START;
        res.ds_write   = 1'b1;
        res.ds_value   = {slot_addr[s], slot_rd[s]};
        res.stat_value = slot_rd[s] ? STAT_START_RD : STAT_START_WR;
    endtask

    // End the transfer with a stop
    task automatic close_transfer(input logic err, inout t_out res);
        seq_phase      = PH_STOP;
        xfer_err       = err;
        res.stat_value = slot_rd[msg_cur[MSG_W-1:0]] ? STAT_STOP_RD : STAT_STOP_WR;
        res.con_action = CON_ACK;
        res.done_res   = 1'b1;
        res.status     = xfer_err;
    endtask

    // Move the base past the current message and open the next one
    task automatic advance_message(inout t_out res);
        base_pos = base_pos + slot_len[msg_cur[MSG_W-1:0]][7:0];
        msg_cur  = msg_cur + 1'b1;
        byte_ptr = '0;
        open_message(res);
    endtask

    // Resume reception, NACK on the last byte, or leave the message
    task automatic after_read(inout t_out res);
        logic [8:0] len;
        len = slot_len[msg_cur[MSG_W-1:0]];
        if (byte_ptr < len) begin
            res.con_action = (byte_ptr + 1 == len) ? CON_NACK : CON_ACK;
        end else if (!on_last_msg()) begin
            advance_message(res);
        end else begin
            close_transfer(1'b0, res);
        end
    endtask

    // Send the next write byte, or leave the message
    task automatic write_next(input logic nak, inout t_out res);
        logic [8:0] len;
        logic [7:0] pos;
        len = slot_len[msg_cur[MSG_W-1:0]];
        pos = base_pos + byte_ptr[7:0];
        if (nak) begin
            close_transfer(1'b1, res);
        end else if (byte_ptr < len) begin
            res.ds_write   = 1'b1;
            res.ds_value   = byte_mem[pos];
            byte_ptr       = byte_ptr + 1'b1;
            res.con_action = CON_ACK;
        end else if (!on_last_msg()) begin
            advance_message(res);
        end else begin
            close_transfer(1'b0, res);
        end
    endtask

    // Apply one request to the predicted state and return its controller step
    task automatic predict_step(input t_in req, output t_out res);
        logic [MSG_W-1:0] s;
        logic [7:0]       pos;
        int               n;
        res = '0;
        s   = msg_cur[MSG_W-1:0];
        case (req.mode)
            MODE_DESC: begin
                slot_addr[req.msg_index] = req.slave_addr;
                slot_rd[req.msg_index]   = req.read_flag;
                slot_len[req.msg_index]  = req.msg_length;
            end
            MODE_DATA: begin
                byte_mem[req.byte_index] = req.data_byte;
            end
            MODE_START: begin
                // drop a start while a transfer is running
                if (!transfer_busy()) begin
                    n = int'(req.msg_count);
                    if (n == 0) n = 1;
                    if (n > MAX_MSGS) n = MAX_MSGS;
                    msg_total = n[TOT_W-1:0];
                    msg_cur   = '0;
                    byte_ptr  = '0;
                    base_pos  = '0;
                    xfer_err  = 1'b1;
                    open_message(res);
                end
            end
            default: begin
                // controller interrupt
                res.irq_clear = 1'b1;
                case (seq_phase)
                    PH_START: begin
                        if (req.no_ack) begin
                            close_transfer(1'b1, res);
                        end else if (on_last_msg() && byte_ptr >= slot_len[s]) begin
                            close_transfer(1'b0, res);
                        end else if (slot_rd[s]) begin
                            seq_phase = PH_READ;
                            after_read(res);
                        end else begin
                            seq_phase = PH_WRITE;
                            write_next(1'b0, res);
                        end
                    end
                    PH_WRITE: begin
                        write_next(req.no_ack, res);
                    end
                    PH_READ: begin
                        pos           = base_pos + byte_ptr[7:0];
                        byte_mem[pos] = req.rx_byte;
                        res.rx_valid  = 1'b1;
                        res.rx_index  = pos;
                        res.rx_data   = req.rx_byte;
                        byte_ptr      = byte_ptr + 1'b1;
                        after_read(res);
                    end
                    default: ;
                endcase
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Request builders
    // ---------------------------------------------------------------

    // Mostly short messages, rarely long ones up to the full store
    function automatic logic [8:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 9'($urandom_range(4));
        if (r < 95) return 9'($urandom_range(16, 5));
        if (r < 98) return 9'($urandom_range(40, 17));
        if (r < 99) return 9'($urandom_range(255, 128));
        return 9'd256;
    endfunction

    // Fill every field at random, then fix the mode
    function automatic t_in rand_request(input logic [1:0] mode);
        logic [63:0] raw;
        t_in         r;
        raw          = {$urandom, $urandom};
        r            = raw[$bits(t_in)-1:0];
        r.mode       = mode;
        r.msg_length = pick_length();
        return r;
    endfunction

    function automatic t_in desc_req(input logic [2:0] slot, input logic [6:0] addr,
                                     input logic rd, input logic [8:0] len);
        t_in r;
        r            = rand_request(MODE_DESC);
        r.msg_index  = slot;
        r.slave_addr = addr;
        r.read_flag  = rd;
        r.msg_length = len;
        return r;
    endfunction

    function automatic t_in data_req(input logic [7:0] idx, input logic [7:0] value);
        t_in r;
        r            = rand_request(MODE_DATA);
        r.byte_index = idx;
        r.data_byte  = value;
        return r;
    endfunction

    function automatic t_in start_req(input logic [3:0] count);
        t_in r;
        r           = rand_request(MODE_START);
        r.msg_count = count;
        return r;
    endfunction

    function automatic t_in irq_req(input logic nak, input logic [7:0] rx);
        t_in r;
        r         = rand_request(MODE_IRQ);
        r.no_ack  = nak;
        r.rx_byte = rx;
        return r;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(60, 15);
        return $urandom_range(4, 1);
    endfunction

    // ---------------------------------------------------------------
    // Request driver and result checker
    // ---------------------------------------------------------------

    // Offer one request, hold it until taken, then predict its step
    task automatic send_request(input t_in req);
        int   gap;
        t_out res;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_step(req, res);
        step_results_q.push_back(res);
        sent_count++;
    endtask

    // Drop valid and wait until every owed step has come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (step_results_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(input string name, input logic [8:0] got,
                                 input logic [8:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (step_results_q.size() == 0) begin
            report_mismatch("result with nothing expected", 9'h0, 9'h0);
        end else begin
            want = step_results_q.pop_front();
            compare_field("ds_write",   9'(got.ds_write),   9'(want.ds_write));
            compare_field("ds_value",   9'(got.ds_value),   9'(want.ds_value));
            compare_field("stat_value", 9'(got.stat_value), 9'(want.stat_value));
            compare_field("con_action", 9'(got.con_action), 9'(want.con_action));
            compare_field("irq_clear",  9'(got.irq_clear),  9'(want.irq_clear));
            compare_field("rx_valid",   9'(got.rx_valid),   9'(want.rx_valid));
            compare_field("rx_index",   9'(got.rx_index),   9'(want.rx_index));
            compare_field("rx_data",    9'(got.rx_data),    9'(want.rx_data));
            compare_field("done_res",   9'(got.done_res),   9'(want.done_res));
            compare_field("status",     9'(got.status),     9'(want.status));
        end
    endtask

    // Take results and stall the output at random or for a requested hold-off
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) check_result(out_data);
            if (hold_cycles > 0) begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // End the run when neither channel moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Write every descriptor slot and every store byte once
    task automatic test_fill_tables();
        for (int s = 0; s < MAX_MSGS; s++) begin
            send_request(desc_req(3'(s), (s == 0) ? 7'h00 : (s == MAX_MSGS - 1) ? 7'h7f
                                  : 7'($urandom_range(127)),
                                  1'($urandom_range(1)), 9'($urandom_range(4))));
        end
        for (int i = 0; i < STORE_BYTES; i++) begin
            send_request(data_req(8'(i), (i == 0) ? 8'hff : (i == 1) ? 8'h00
                                  : 8'($urandom_range(255))));
        end
    endtask

    // Interrupt with no transfer running: clear only
    task automatic test_idle_interrupt();
        send_request(irq_req(1'b1, 8'hff));
    endtask

    // Single write message, count zero, extra interrupt after the stop
    task automatic test_write_message();
        send_request(desc_req(3'd0, 7'h7f, 1'b0, 9'd2));
        send_request(start_req(4'd0));
        send_request(irq_req(1'b0, 8'h00));
        send_request(irq_req(1'b0, 8'h00));
        send_request(irq_req(1'b0, 8'h00));
        send_request(irq_req(1'b0, 8'hff));
    endtask

    // Read with NACK on its only byte, repeated start into an empty write
    task automatic test_read_repeated_start();
        send_request(desc_req(3'd0, 7'h00, 1'b1, 9'd1));
        send_request(desc_req(3'd1, 7'h2a, 1'b0, 9'd0));
        send_request(start_req(4'd2));
        send_request(irq_req(1'b0, 8'h00));
        send_request(start_req(4'd1));
        send_request(irq_req(1'b0, 8'hff));
        send_request(irq_req(1'b0, 8'h5a));
    endtask

    // No ACK on the address and on a data byte; saturated count
    task automatic test_missing_ack();
        send_request(start_req(4'd15));
        send_request(irq_req(1'b1, 8'h00));
        send_request(desc_req(3'd0, 7'h55, 1'b0, 9'd256));
        send_request(start_req(4'd1));
        send_request(irq_req(1'b0, 8'h00));
        send_request(irq_req(1'b0, 8'h00));
        send_request(irq_req(1'b1, 8'hff));
    endtask

    // Hold the output off while requests keep coming, then drain
    task automatic test_output_backpressure();
        idle_pct    = 0;
        hold_cycles = 80;
        repeat (16) send_request(rand_request(2'($urandom_range(1))));
        wait_for_drain();
    endtask

    // Mostly complete transfers with random content, some noise between
    task automatic test_random_transfers();
        int stop_at;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(4, 1))
                    send_request(rand_request(2'($urandom_range(3))));
            end else begin
                repeat ($urandom_range(3))
                    send_request(desc_req(3'($urandom_range(7)), 7'($urandom_range(127)),
                                          1'($urandom_range(1)), pick_length()));
                repeat ($urandom_range(3))
                    send_request(data_req(8'($urandom_range(255)),
                                          8'($urandom_range(255))));
                send_request(start_req(4'(($urandom_range(3) == 0) ? $urandom_range(15)
                                          : $urandom_range(3, 1))));
                // advance the transfer until it stops
                while (transfer_busy()) begin
                    if ($urandom_range(99) < 5)
                        send_request(rand_request(2'($urandom_range(2))));
                    else
                        send_request(irq_req($urandom_range(29) == 0,
                                             8'($urandom_range(255))));
                end
                if ($urandom_range(3) == 0)
                    send_request(irq_req(1'($urandom_range(1)), 8'($urandom_range(255))));
            end
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_tables();
        test_idle_interrupt();
        test_write_message();
        test_read_repeated_start();
        test_missing_ack();
        wait_for_drain();
        test_output_backpressure();
        test_random_transfers();
        wait_for_drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
